// ===== sv/affine_vertex_transform_macros.svh =====
// Assertion macros shared by the vertex transform RTL.
`ifndef AFFINE_VERTEX_TRANSFORM_MACROS_SVH
`define AFFINE_VERTEX_TRANSFORM_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/avt_pkg.sv =====
package avt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_ROWS      = 3;
  localparam int NUM_COLS      = 4;

  localparam logic [1:0] ROW_NONE = 2'd3;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_POS  = 2'd1,
    OP_DIR  = 2'd2,
    OP_RSVD = 2'd3
  } avt_op_t;

  // Matrix entry write aimed at one row lane.
  typedef struct packed {
    logic               we;
    logic [1:0]         col;
    logic signed [31:0] value;
  } avt_wr_t;

endpackage

// ===== sv/avt_lane.sv =====
module avt_lane #(
  parameter int ROW       = 0,
  parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF,
  localparam int SumW     = 64 - FRAC_BITS + 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  avt_pkg::avt_wr_t       wr,
  input  logic                   pos,
  input  logic signed [31:0]     vec_x,
  input  logic signed [31:0]     vec_y,
  input  logic signed [31:0]     vec_z,
  output logic signed [SumW-1:0] sum
);

  localparam logic signed [31:0] Ident = 32'(1) << FRAC_BITS;

  logic signed [31:0]     row_r [avt_pkg::NUM_COLS];
  logic signed [63:0]     prod_r [3];
  logic signed [63:0]     prod_nxt [3];
  logic signed [31:0]     trans_r;
  logic signed [SumW-1:0] sum_r;
  logic signed [SumW-1:0] sum_nxt;

  // The row of the matrix this lane owns; reset loads the identity row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < avt_pkg::NUM_COLS; c++) begin
        row_r[c] <= (c == ROW) ? Ident : '0;
      end
    end else if (wr.we) begin
      row_r[wr.col] <= wr.value;
    end
  end

  always_comb begin
    prod_nxt[0] = 64'(row_r[0]) * 64'(vec_x);
    prod_nxt[1] = 64'(row_r[1]) * 64'(vec_y);
    prod_nxt[2] = 64'(row_r[2]) * 64'(vec_z);
  end

  // Arithmetic shift floors each product before the exact sum.
  always_comb begin
    sum_nxt = SumW'(prod_r[0] >>> FRAC_BITS) + SumW'(prod_r[1] >>> FRAC_BITS)
            + SumW'(prod_r[2] >>> FRAC_BITS) + SumW'(trans_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= prod_nxt[c];
      end
      trans_r <= pos ? row_r[3] : '0;
      sum_r   <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// ===== sv/avt_merge.sv =====
module avt_merge #(
  parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF,
  localparam int SumW     = 64 - FRAC_BITS + 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [SumW-1:0] sum_x,
  input  logic signed [SumW-1:0] sum_y,
  input  logic signed [SumW-1:0] sum_z,
  output logic                   out_valid,
  output logic signed [31:0]     x,
  output logic signed [31:0]     y,
  output logic signed [31:0]     z,
  output logic                   clip
);

  logic               valid_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic               clip_r;
  logic               fit_x, fit_y, fit_z;
  logic signed [31:0] x_nxt, y_nxt, z_nxt;

  function automatic logic fits(input logic signed [SumW-1:0] s);
    fits = (&s[SumW-1:31]) || !(|s[SumW-1:31]);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [SumW-1:0] s);
    if (fits(s)) begin
      sat = s[31:0];
    end else begin
      sat = s[SumW-1] ? avt_pkg::S32_MIN : avt_pkg::S32_MAX;
    end
  endfunction

  always_comb begin
    fit_x = fits(sum_x);
    fit_y = fits(sum_y);
    fit_z = fits(sum_z);
    x_nxt = sat(sum_x);
    y_nxt = sat(sum_y);
    z_nxt = sat(sum_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      clip_r <= !(fit_x && fit_y && fit_z);
    end
  end

  assign out_valid = valid_r;
  assign x         = x_r;
  assign y         = y_r;
  assign z         = z_r;
  assign clip      = clip_r;

endmodule

// ===== sv/affine_vertex_transform.sv =====
// Pipeline: a transform beat passes the input register, then the multiply, sum and
// saturate registers, in that order, before it shows on out_tvalid.
// Throughput: one beat per cycle; the whole pipeline holds only while a result waits
// in the output register and out_tready is low. Loads give no result.
// Reset: the matrix returns to identity and the pipeline empties.
`include "affine_vertex_transform_macros.svh"

module affine_vertex_transform #(
  parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // row_sel[1:0], col_sel[3:2], entry_value[35:4], vec_x[67:36], vec_y[99:68],
  // vec_z[131:100], zero fill up to 135
  input  logic [135:0] in_tdata,
  // op[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]  out_tdata,
  // clipped[0]
  output logic [0:0]   out_tuser
);

  localparam int SumW = 64 - FRAC_BITS + 2;

  avt_pkg::avt_op_t   op;
  logic [1:0]         row_sel;
  logic [1:0]         col_sel;
  logic signed [31:0] entry_value;
  logic signed [31:0] vec_x, vec_y, vec_z;

  logic en;
  logic acc;
  logic is_xform;
  logic is_load;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_pos_r;
  logic signed [31:0] s1_x_r, s1_y_r, s1_z_r;
  logic               s2_valid_r;
  logic               s3_valid_r;

  logic signed [SumW-1:0] lane_sum [avt_pkg::NUM_ROWS];
  avt_pkg::avt_wr_t       lane_wr  [avt_pkg::NUM_ROWS];

  logic               res_valid;
  logic signed [31:0] res_x, res_y, res_z;
  logic               res_clip;
  logic               res_at_rail;

  assign op          = avt_pkg::avt_op_t'(in_tuser);
  assign row_sel     = in_tdata[1:0];
  assign col_sel     = in_tdata[3:2];
  assign entry_value = in_tdata[35:4];
  assign vec_x       = in_tdata[67:36];
  assign vec_y       = in_tdata[99:68];
  assign vec_z       = in_tdata[131:100];

  // Every stage moves together; only a held result in the output register stops it.
  assign en        = !res_valid || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  always_comb begin
    is_xform = 1'b0;
    is_load  = 1'b0;
    case (op)
      avt_pkg::OP_LOAD: is_load  = acc && (row_sel != avt_pkg::ROW_NONE);
      avt_pkg::OP_POS:  is_xform = acc;
      avt_pkg::OP_DIR:  is_xform = acc;
      default: begin
        is_xform = 1'b0;
        is_load  = 1'b0;
      end
    endcase
    s1_valid_nxt = is_xform;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos_r <= (op == avt_pkg::OP_POS);
      s1_x_r   <= vec_x;
      s1_y_r   <= vec_y;
      s1_z_r   <= vec_z;
    end
  end

  for (genvar r = 0; r < avt_pkg::NUM_ROWS; r++) begin : g_lane
    always_comb begin
      lane_wr[r].we    = is_load && (row_sel == 2'(r));
      lane_wr[r].col   = col_sel;
      lane_wr[r].value = entry_value;
    end

    avt_lane #(
      .ROW       (r),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .wr    (lane_wr[r]),
      .pos   (s1_pos_r),
      .vec_x (s1_x_r),
      .vec_y (s1_y_r),
      .vec_z (s1_z_r),
      .sum   (lane_sum[r])
    );
  end

  avt_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_valid_r),
    .sum_x     (lane_sum[0]),
    .sum_y     (lane_sum[1]),
    .sum_z     (lane_sum[2]),
    .out_valid (res_valid),
    .x         (res_x),
    .y         (res_y),
    .z         (res_z),
    .clip      (res_clip)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {res_z, res_y, res_x};
  assign out_tuser  = res_clip;

  assign res_at_rail = (res_x == avt_pkg::S32_MAX) || (res_x == avt_pkg::S32_MIN)
                    || (res_y == avt_pkg::S32_MAX) || (res_y == avt_pkg::S32_MIN)
                    || (res_z == avt_pkg::S32_MAX) || (res_z == avt_pkg::S32_MIN);

  `AVT_ASSERT_NOW(a_clip_at_rail, res_valid && res_clip, res_at_rail, "clip flag without a rail")
  `AVT_ASSERT_NEXT(a_s1_advance, s1_valid_r && en, s2_valid_r, "transform lost after input stage")
  `AVT_ASSERT_NOW(a_stall_cause, !in_tready, res_valid && !out_tready, "needless input stall")

endmodule

// ===== test/tb_affine_vertex_transform.sv =====
module tb_affine_vertex_transform;
  import avt_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEMS_PER_RUN = 500;
  localparam int N_DIRECTED    = 23;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        clipped;
  } vertex_t;

  typedef struct packed {
    avt_op_t     op;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] entry;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        typed;
    vertex_t     want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0]   in_tuser = OP_RSVD;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic [0:0]   out_tuser;

  // Travels with the beat on the input: a hand-written result replaces the prediction.
  logic         beat_typed = 1'b0;
  vertex_t      beat_want = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned n_errors = 0;
  int unsigned n_loads = 0;
  int unsigned n_transforms = 0;
  int unsigned n_ignored = 0;
  int unsigned n_checked = 0;
  int unsigned n_clipped = 0;

  logic signed [31:0] matrix_copy [NUM_ROWS][NUM_COLS];
  vertex_t            pending_vertices [$];

  avt_op_t     acc_op;
  logic [1:0]  acc_row;
  logic [1:0]  acc_col;
  vertex_t     acc_vertex;
  vertex_t     got_vertex;
  vertex_t     want_vertex;
  int unsigned counted;

  // Directed beats: op, row, col, entry, x, y, z, typed, expected x, y, z, clipped.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_POS,  2'd0, 2'd0, 32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
      1'b1, '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0}},
    '{OP_DIR,  2'd0, 2'd0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
      1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0}},
    '{OP_RSVD, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b0, '0},
    '{OP_LOAD, ROW_NONE, 2'd3, 32'h1234_5678, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0,
      1'b0, '0},
    '{OP_POS,  2'd3, 2'd3, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
      1'b1, '{32'h0, 32'h0, 32'h0, 1'b0}},
    '{OP_LOAD, 2'd0, 2'd3, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_POS,  2'd0, 2'd0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
      1'b1, '{32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1}},
    '{OP_DIR,  2'd0, 2'd0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
      1'b1, '{32'h0001_0000, 32'h0, 32'h0, 1'b0}},
    '{OP_LOAD, 2'd1, 2'd3, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_POS,  2'd0, 2'd0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0,
      1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1}},
    '{OP_LOAD, 2'd2, 2'd2, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_DIR,  2'd0, 2'd0, 32'h0, 32'h0, 32'h0, 32'h8000_0000,
      1'b1, '{32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1}},
    '{OP_LOAD, 2'd2, 2'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_DIR,  2'd0, 2'd0, 32'h0, 32'h1, 32'h0, 32'h0,
      1'b1, '{32'h1, 32'h0, 32'hFFFF_FFFF, 1'b0}},
    '{OP_POS,  2'd0, 2'd0, 32'h0, 32'h1, 32'h0, 32'h0,
      1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1}},
    '{OP_LOAD, 2'd0, 2'd1, 32'h0001_8000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_LOAD, 2'd1, 2'd2, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_LOAD, 2'd0, 2'd3, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_POS,  2'd0, 2'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      1'b0, '0},
    '{OP_DIR,  2'd0, 2'd0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
      1'b0, '0},
    '{OP_POS,  2'd2, 2'd1, 32'h0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
      1'b0, '0},
    '{OP_LOAD, 2'd1, 2'd0, 32'hFFFE_8000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_DIR,  2'd0, 2'd0, 32'h0, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000,
      1'b0, '0}
  };

  affine_vertex_transform i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Each output lane: three products floored back to the fixed point, the translation
  // in position mode, then saturation to 32 bits.
  function automatic vertex_t transform_vertex(avt_op_t op, logic signed [31:0] vx,
                                               logic signed [31:0] vy,
                                               logic signed [31:0] vz);
    logic signed [31:0] vec [3];
    logic signed [31:0] lane [3];
    logic signed [63:0] m64;
    logic signed [63:0] v64;
    logic signed [63:0] acc;
    vertex_t            res;
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    res = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      acc = '0;
      for (int c = 0; c < 3; c++) begin
        m64 = matrix_copy[r][c];
        v64 = vec[c];
        acc = acc + ((m64 * v64) >>> FRAC_BITS_DEF);
      end
      if (op == OP_POS) begin
        m64 = matrix_copy[r][3];
        acc = acc + m64;
      end
      if (acc > S32_MAX) begin
        lane[r] = S32_MAX;
        res.clipped = 1'b1;
      end else if (acc < S32_MIN) begin
        lane[r] = S32_MIN;
        res.clipped = 1'b1;
      end else begin
        lane[r] = acc[31:0];
      end
    end
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    return res;
  endfunction

  // Mostly small values below 8.0 in magnitude, some full-range words, some corner values.
  function automatic logic [31:0] rand_fixed();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      return 32'($urandom_range(32'h000F_FFFF)) - 32'h0008_0000;
    end
    if (pick < 85) begin
      return $urandom;
    end
    case ($urandom_range(6))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0001_0000;
      4: return 32'hFFFF_0000;
      5: return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  task automatic check_lane(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic send_beat(avt_op_t op, logic [1:0] row, logic [1:0] col,
                           logic [31:0] entry, logic [31:0] vx, logic [31:0] vy,
                           logic [31:0] vz, logic typed, vertex_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= op;
    in_tdata   <= {4'b0, vz, vy, vx, entry, col, row};
    beat_typed <= typed;
    beat_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() != 0) @(posedge clk);
  endtask

  // Returns 1 when the beat does something the block acts on.
  task automatic send_random_beat(output logic useful);
    int unsigned kind;
    avt_op_t     op;
    logic [1:0]  row;
    kind = $urandom_range(99);
    row = 2'($urandom_range(3));
    useful = 1'b1;
    if (kind < 20) begin
      op = OP_LOAD;
      row = 2'($urandom_range(NUM_ROWS - 1));
    end else if (kind < 25) begin
      op = OP_LOAD;
      row = ROW_NONE;
      useful = 1'b0;
    end else if (kind < 62) begin
      op = OP_POS;
    end else if (kind < 97) begin
      op = OP_DIR;
    end else begin
      op = OP_RSVD;
      useful = 1'b0;
    end
    if (op == OP_LOAD) begin
      send_beat(op, row, 2'($urandom_range(3)), rand_fixed(), $urandom, $urandom, $urandom,
                1'b0, '0);
    end else begin
      send_beat(op, row, 2'($urandom_range(3)), $urandom, rand_fixed(), rand_fixed(),
                rand_fixed(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Input side: every accepted beat updates the matrix copy, queues a vertex or counts as ignored.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      acc_op  = avt_op_t'(in_tuser);
      acc_row = in_tdata[1:0];
      acc_col = in_tdata[3:2];
      case (acc_op)
        OP_LOAD: begin
          if (acc_row != ROW_NONE) begin
            matrix_copy[acc_row][acc_col] = in_tdata[35:4];
            n_loads++;
          end else begin
            n_ignored++;
          end
        end
        OP_POS, OP_DIR: begin
          acc_vertex = transform_vertex(acc_op, in_tdata[67:36], in_tdata[99:68],
                                        in_tdata[131:100]);
          pending_vertices.push_back(beat_typed ? beat_want : acc_vertex);
          n_transforms++;
        end
        default: begin
          n_ignored++;
        end
      endcase
    end
  end

  // Output side: each result beat against the oldest pending vertex.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_vertex = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tuser[0]};
      if (pending_vertices.size() == 0) begin
        n_errors++;
        $display("%0t: result beat with none expected, got %h %h %h clipped %b", $time,
                 got_vertex.x, got_vertex.y, got_vertex.z, got_vertex.clipped);
      end else begin
        want_vertex = pending_vertices.pop_front();
        check_lane("out_x", want_vertex.x, got_vertex.x);
        check_lane("out_y", want_vertex.y, got_vertex.y);
        check_lane("out_z", want_vertex.z, got_vertex.z);
        check_lane("clipped", 32'(want_vertex.clipped), 32'(got_vertex.clipped));
        n_checked++;
        if (got_vertex.clipped) n_clipped++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_vertices.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic useful;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        matrix_copy[r][c] = (r == c) ? (32'sd1 <<< FRAC_BITS_DEF) : 32'sd0;
      end
    end
    send_idle_pct = 12;
    recv_idle_pct = 78;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_beat(DIRECTED[i].op, DIRECTED[i].row, DIRECTED[i].col, DIRECTED[i].entry,
                DIRECTED[i].vx, DIRECTED[i].vy, DIRECTED[i].vz, DIRECTED[i].typed,
                DIRECTED[i].want);
    end
    drain_results();

    // Three runs: slow receiver, slow sender, then full rate on both sides.
    for (int run = 0; run < 3; run++) begin
      send_idle_pct = (run == 0) ? 12 : (run == 1) ? 78 : 0;
      recv_idle_pct = (run == 0) ? 78 : (run == 1) ? 12 : 0;
      counted = 0;
      while (counted < ITEMS_PER_RUN) begin
        send_random_beat(useful);
        if (useful) counted++;
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d matrix loads, %0d transforms and %0d ignored beats;", n_loads,
             n_transforms, n_ignored);
    $display("checked %0d vertices, %0d of them clipped.", n_checked, n_clipped);
    if (n_errors == 0 && pending_vertices.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
